FILE: rtl/core/coupled_ar3_population_step_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coupled AR(3) population step
// Shared property shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef COUPLED_AR3_POPULATION_STEP_MACROS_SVH
`define COUPLED_AR3_POPULATION_STEP_MACROS_SVH

// same-cycle implication
`define CPOP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpop assertion failed");

// next-cycle implication
`define CPOP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpop assertion failed");

`endif

FILE: rtl/core/cpop_pkg.sv
// ----------------------------------------------------------------------------
// cpop_pkg
// Types, constants and rounding helpers of the coupled AR(3) population step.
// ----------------------------------------------------------------------------
package cpop_pkg;

	localparam int SPECIES   = 16;
	localparam int SP_W      = $clog2(SPECIES);
	localparam int CNT_W     = 5;
	localparam int STEP_W    = 16;
	localparam int VAL_W     = 24;
	localparam int WORD_W    = 32;
	localparam int PROD_W    = VAL_W + WORD_W;
	localparam int ACC_W     = 64;
	localparam int TOTAL_W   = WORD_W + SP_W + 1;
	localparam int WGT_SLOTS = 8;
	localparam int WGT_DEPTH = SPECIES * WGT_SLOTS;
	localparam int MAT_DEPTH = SPECIES * SPECIES;
	localparam int HIST_DEPTH = SPECIES * 4;
	localparam logic [STEP_W-1:0] STEP_MAX = '1;
	localparam logic signed [VAL_W-1:0] ONE_Q20 = VAL_W'(1 << 20);

	// weight slots within a species row
	localparam logic [2:0] SLOT_RHO = 3'd4;
	localparam logic [2:0] SLOT_IND = 3'd5;

	typedef enum logic [1:0] {
		OP_LOAD_MATRIX = 2'd0,
		OP_LOAD_WEIGHT = 2'd1,
		OP_NOISE       = 2'd2,
		OP_RESTART     = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_MIX,
		ST_UNC,
		ST_CPL,
		ST_SH0,
		ST_SH1,
		ST_SH2,
		ST_SH3,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] val;
		logic                     clip;
	} rsat_t;

	// add half, floor shift by 20, saturate to 32 bits
	function automatic rsat_t round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		rsat_t r;
		t = (acc + ACC_W'(64'sd1 <<< 19)) >>> 20;
		if (t > ACC_W'(64'sh7FFF_FFFF)) begin
			r.val = 32'sh7FFF_FFFF;
			r.clip = 1'b1;
		end else if (t < -ACC_W'(64'sh8000_0000)) begin
			r.val = 32'sh8000_0000;
			r.clip = 1'b1;
		end else begin
			r.val = t[WORD_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

	function automatic rsat_t sat_total(input logic signed [TOTAL_W-1:0] x);
		rsat_t r;
		if (x > TOTAL_W'(64'sh7FFF_FFFF)) begin
			r.val = 32'sh7FFF_FFFF;
			r.clip = 1'b1;
		end else if (x < -TOTAL_W'(64'sh8000_0000)) begin
			r.val = 32'sh8000_0000;
			r.clip = 1'b1;
		end else begin
			r.val = x[WORD_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/cpop_if.sv
// ----------------------------------------------------------------------------
// cpop channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface cpop_sample_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         operation;
	logic [3:0]                         row;
	logic [3:0]                         column;
	logic signed [cpop_pkg::VAL_W-1:0]  value;
	logic signed [cpop_pkg::VAL_W-1:0]  own_noise;
	logic signed [cpop_pkg::VAL_W-1:0]  shared_noise;
	logic                               last_species;
	modport source (output valid, operation, row, column, value, own_noise,
		shared_noise, last_species, input ready);
	modport sink (input valid, operation, row, column, value, own_noise,
		shared_noise, last_species, output ready);
endinterface

interface cpop_result_if;
	logic                                valid;
	logic                                ready;
	logic [cpop_pkg::STEP_W-1:0]         step_index;
	logic signed [cpop_pkg::WORD_W-1:0]  population_sum;
	logic                                saturated;
	modport source (output valid, step_index, population_sum, saturated, input ready);
	modport sink (input valid, step_index, population_sum, saturated, output ready);
endinterface

interface cpop_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [cpop_pkg::CNT_W-1:0]  data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/cpop_ram.sv
// ----------------------------------------------------------------------------
// cpop_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cpop_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/coupled_ar3_population_step.sv
// ----------------------------------------------------------------------------
// coupled_ar3_population_step
// Coupled third-order autoregressive population step on one shared MAC.
// ----------------------------------------------------------------------------
// Load and restart items complete when accepted; a noise item runs from the
// accept through 6 MAC terms (read, multiply, accumulate) and 2 roundings.
// A last_species item adds n+1 MAC terms on the single MAC, a coupling round
// and a history RAM shift for each of n active species, plus any wait for
// an unread result. Reset clears history valid bits, step counter, clip
// flag and result valid; species_count resets to 16. Matrix and weights hold.
module coupled_ar3_population_step (
	input  logic                 clk,
	input  logic                 arst_n,
	cpop_sample_if.sink          sample,
	cpop_result_if.source        result,
	cpop_cfg_if.sink             cfg
);
	cpop_pkg::state_t state_q, state_d;

	logic [cpop_pkg::CNT_W-1:0]  count_q;
	logic [cpop_pkg::CNT_W-1:0]  n_act;
	logic                        noise_ph_q;
	logic [cpop_pkg::CNT_W-1:0]  k_q;
	logic [cpop_pkg::SP_W-1:0]   i_q;
	logic [cpop_pkg::SP_W-1:0]   j_idx;
	logic [cpop_pkg::SP_W-1:0]   row_q;
	logic                        last_q;
	logic signed [cpop_pkg::VAL_W-1:0] own_q, shared_q;
	logic [cpop_pkg::SPECIES-1:0] hvalid_q;
	logic [cpop_pkg::STEP_W-1:0] step_q;
	logic                        clip_q;
	logic signed [cpop_pkg::WORD_W-1:0]  mixed_q, cpl_q;
	logic signed [cpop_pkg::PROD_W-1:0]  prod_q;
	logic signed [cpop_pkg::ACC_W-1:0]   acc_q;
	logic signed [cpop_pkg::TOTAL_W-1:0] total_q;

	logic                        res_valid_q;
	logic [cpop_pkg::STEP_W-1:0] res_step_q;
	logic signed [cpop_pkg::WORD_W-1:0] res_sum_q;
	logic                        res_sat_q;

	logic accept;
	logic signed [cpop_pkg::WORD_W-1:0] mul_a;
	logic signed [cpop_pkg::VAL_W-1:0]  mul_b;
	cpop_pkg::rsat_t rnd, tot;

	// RAM ports
	logic                                  mat_we, wgt_we, hist_we, unc_we;
	logic [$clog2(cpop_pkg::MAT_DEPTH)-1:0]  mat_waddr, mat_raddr;
	logic [$clog2(cpop_pkg::WGT_DEPTH)-1:0]  wgt_waddr, wgt_raddr;
	logic [$clog2(cpop_pkg::HIST_DEPTH)-1:0] hist_waddr, hist_raddr;
	logic [cpop_pkg::SP_W-1:0]              unc_waddr, unc_raddr;
	logic [cpop_pkg::VAL_W-1:0]  mat_rd, wgt_rd;
	logic [cpop_pkg::WORD_W-1:0] hist_rd, unc_rd, hist_wdata, unc_wdata;

	cpop_ram #(.WIDTH(cpop_pkg::VAL_W), .DEPTH(cpop_pkg::MAT_DEPTH)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(sample.value),
		.raddr(mat_raddr), .rdata(mat_rd));
	cpop_ram #(.WIDTH(cpop_pkg::VAL_W), .DEPTH(cpop_pkg::WGT_DEPTH)) u_wgt (
		.clk(clk), .we(wgt_we), .waddr(wgt_waddr), .wdata(sample.value),
		.raddr(wgt_raddr), .rdata(wgt_rd));
	cpop_ram #(.WIDTH(cpop_pkg::WORD_W), .DEPTH(cpop_pkg::HIST_DEPTH)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
		.raddr(hist_raddr), .rdata(hist_rd));
	cpop_ram #(.WIDTH(cpop_pkg::WORD_W), .DEPTH(cpop_pkg::SPECIES)) u_unc (
		.clk(clk), .we(unc_we), .waddr(unc_waddr), .wdata(unc_wdata),
		.raddr(unc_raddr), .rdata(unc_rd));

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == cpop_pkg::ST_IDLE);
	assign accept       = sample.valid && sample.ready;

	assign result.valid          = res_valid_q;
	assign result.step_index     = res_step_q;
	assign result.population_sum = res_sum_q;
	assign result.saturated      = res_sat_q;

	// clamp species count to 1..SPECIES
	always_comb begin
		if (count_q == '0) begin
			n_act = cpop_pkg::CNT_W'(1);
		end else if (count_q > cpop_pkg::CNT_W'(cpop_pkg::SPECIES)) begin
			n_act = cpop_pkg::CNT_W'(cpop_pkg::SPECIES);
		end else begin
			n_act = count_q;
		end
	end

	assign j_idx = cpop_pkg::SP_W'(k_q - cpop_pkg::CNT_W'(1));
	assign rnd   = cpop_pkg::round_sat(acc_q);
	assign tot   = cpop_pkg::sat_total(total_q);

	// loads write straight from the sample beat
	always_comb begin
		mat_we    = accept && (sample.operation == cpop_pkg::OP_LOAD_MATRIX);
		mat_waddr = {sample.row, sample.column};
		wgt_we    = accept && (sample.operation == cpop_pkg::OP_LOAD_WEIGHT) &&
			(sample.column < 4'd6);
		wgt_waddr = {sample.row, sample.column[2:0]};
	end

	// read addresses
	always_comb begin
		wgt_raddr  = {row_q, 3'd0};
		hist_raddr = {row_q, 2'd1};
		mat_raddr  = {j_idx, i_q};
		unc_raddr  = i_q;
		if (noise_ph_q) begin
			unique case (k_q)
				5'd0:    wgt_raddr = {row_q, cpop_pkg::SLOT_RHO};
				5'd1:    wgt_raddr = {row_q, cpop_pkg::SLOT_IND};
				default: wgt_raddr = {row_q, 3'(k_q - 5'd2)};
			endcase
			hist_raddr = {row_q, 2'(k_q - 5'd2)};
		end else begin
			if (k_q != '0) begin
				unc_raddr = j_idx;
			end
			if (state_q == cpop_pkg::ST_SH0) begin
				hist_raddr = {i_q, 2'd2};
			end else if (state_q == cpop_pkg::ST_SH1) begin
				hist_raddr = {i_q, 2'd1};
			end
		end
	end

	// MAC operand select, data is valid in ST_MUL
	always_comb begin
		mul_a = unc_rd;
		mul_b = wgt_rd;
		if (noise_ph_q) begin
			unique case (k_q)
				5'd0: mul_a = cpop_pkg::WORD_W'(shared_q);
				5'd1: mul_a = cpop_pkg::WORD_W'(own_q);
				5'd2: begin
					mul_a = mixed_q;
					if (step_q == '0) begin
						mul_b = cpop_pkg::ONE_Q20;
					end
				end
				default: mul_a = hvalid_q[row_q] ? hist_rd : '0;
			endcase
		end else if (k_q == '0) begin
			mul_b = cpop_pkg::ONE_Q20;
		end else begin
			mul_b = mat_rd;
		end
	end

	// write ports of history and uncoupled vector
	always_comb begin
		unc_we     = (state_q == cpop_pkg::ST_UNC);
		unc_waddr  = row_q;
		unc_wdata  = rnd.val;
		hist_we    = 1'b0;
		hist_waddr = {i_q, 2'd1};
		hist_wdata = cpl_q;
		unique case (state_q)
			cpop_pkg::ST_SH1: begin
				hist_we    = 1'b1;
				hist_waddr = {i_q, 2'd3};
				hist_wdata = hvalid_q[i_q] ? hist_rd : '0;
			end
			cpop_pkg::ST_SH2: begin
				hist_we    = 1'b1;
				hist_waddr = {i_q, 2'd2};
				hist_wdata = hvalid_q[i_q] ? hist_rd : '0;
			end
			cpop_pkg::ST_SH3: begin
				hist_we = 1'b1;
			end
			default: begin
				hist_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpop_pkg::ST_IDLE: begin
				if (accept && (sample.operation == cpop_pkg::OP_NOISE)) begin
					state_d = cpop_pkg::ST_RD;
				end
			end
			cpop_pkg::ST_RD:  state_d = cpop_pkg::ST_MUL;
			cpop_pkg::ST_MUL: state_d = cpop_pkg::ST_ACC;
			cpop_pkg::ST_ACC: begin
				if (noise_ph_q) begin
					if (k_q == 5'd1) begin
						state_d = cpop_pkg::ST_MIX;
					end else if (k_q == 5'd5) begin
						state_d = cpop_pkg::ST_UNC;
					end else begin
						state_d = cpop_pkg::ST_RD;
					end
				end else if (k_q == n_act) begin
					state_d = cpop_pkg::ST_CPL;
				end else begin
					state_d = cpop_pkg::ST_RD;
				end
			end
			cpop_pkg::ST_MIX: state_d = cpop_pkg::ST_RD;
			cpop_pkg::ST_UNC: state_d = last_q ? cpop_pkg::ST_RD : cpop_pkg::ST_IDLE;
			cpop_pkg::ST_CPL: state_d = cpop_pkg::ST_SH0;
			cpop_pkg::ST_SH0: state_d = cpop_pkg::ST_SH1;
			cpop_pkg::ST_SH1: state_d = cpop_pkg::ST_SH2;
			cpop_pkg::ST_SH2: state_d = cpop_pkg::ST_SH3;
			cpop_pkg::ST_SH3: begin
				if ({1'b0, i_q} == n_act - cpop_pkg::CNT_W'(1)) begin
					state_d = cpop_pkg::ST_OUT;
				end else begin
					state_d = cpop_pkg::ST_RD;
				end
			end
			cpop_pkg::ST_OUT: begin
				if (!res_valid_q || result.ready) begin
					state_d = cpop_pkg::ST_IDLE;
				end
			end
			default: state_d = cpop_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpop_pkg::ST_IDLE;
			count_q     <= cpop_pkg::CNT_W'(cpop_pkg::SPECIES);
			hvalid_q    <= '0;
			step_q      <= '0;
			clip_q      <= 1'b0;
			res_valid_q <= 1'b0;
			noise_ph_q  <= 1'b1;
			k_q         <= '0;
			i_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				count_q <= cfg.data;
			end
			// load a new beat into the output slot, or drop the one taken
			if ((state_q == cpop_pkg::ST_OUT) && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				cpop_pkg::ST_IDLE: begin
					if (accept && (sample.operation == cpop_pkg::OP_RESTART)) begin
						hvalid_q <= '0;
						step_q   <= '0;
						clip_q   <= 1'b0;
					end
					noise_ph_q <= 1'b1;
					k_q        <= '0;
				end
				cpop_pkg::ST_ACC: begin
					k_q <= k_q + cpop_pkg::CNT_W'(1);
				end
				cpop_pkg::ST_MIX: begin
					clip_q <= clip_q | rnd.clip;
				end
				cpop_pkg::ST_UNC: begin
					clip_q     <= clip_q | rnd.clip;
					noise_ph_q <= 1'b0;
					k_q        <= '0;
					i_q        <= '0;
				end
				cpop_pkg::ST_CPL: begin
					clip_q <= clip_q | rnd.clip;
				end
				cpop_pkg::ST_SH3: begin
					hvalid_q[i_q] <= 1'b1;
					i_q           <= i_q + cpop_pkg::SP_W'(1);
					k_q           <= '0;
				end
				cpop_pkg::ST_OUT: begin
					if (!res_valid_q || result.ready) begin
						clip_q <= 1'b0;
						if (step_q != cpop_pkg::STEP_MAX) begin
							step_q <= step_q + cpop_pkg::STEP_W'(1);
						end
					end
				end
				default: begin
					clip_q <= clip_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q    <= sample.row;
			own_q    <= sample.own_noise;
			shared_q <= sample.shared_noise;
			last_q   <= sample.last_species;
			acc_q    <= '0;
			total_q  <= '0;
		end
		unique case (state_q)
			cpop_pkg::ST_MUL: prod_q <= cpop_pkg::PROD_W'(mul_a * mul_b);
			cpop_pkg::ST_ACC: acc_q  <= acc_q + cpop_pkg::ACC_W'(prod_q);
			cpop_pkg::ST_MIX: begin
				mixed_q <= rnd.val;
				acc_q   <= '0;
			end
			cpop_pkg::ST_UNC: acc_q <= '0;
			cpop_pkg::ST_CPL: begin
				cpl_q   <= rnd.val;
				total_q <= total_q + cpop_pkg::TOTAL_W'(rnd.val);
				acc_q   <= '0;
			end
			cpop_pkg::ST_OUT: begin
				if (!res_valid_q || result.ready) begin
					res_step_q <= step_q;
					res_sum_q  <= tot.val;
					res_sat_q  <= clip_q | tot.clip;
				end
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end
endmodule

FILE: rtl/core/cpop_checker.sv
// ----------------------------------------------------------------------------
// cpop_checker
// Port-level checks of the population step, bound to the top level.
// ----------------------------------------------------------------------------
`include "coupled_ar3_population_step_macros.svh"

module cpop_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_valid,
	input logic        s_ready,
	input logic [1:0]  s_op,
	input logic        r_valid,
	input logic        r_ready,
	input logic [31:0] r_sum
);
	// a result beat waits for ready
	`CPOP_ASSERT_NXT(a_res_hold, r_valid && !r_ready, r_valid)
	`CPOP_ASSERT_NXT(a_res_stable, r_valid && !r_ready, $stable(r_sum))
	// an accepted noise beat makes the block busy (not ready) in the next cycle
	`CPOP_ASSERT_NXT(a_noise_busy, s_valid && s_ready && (s_op == cpop_pkg::OP_NOISE),
		!s_ready)
	// results are only produced from the busy state
	`CPOP_ASSERT_IMP(a_res_from_busy, $rose(r_valid), $past(!s_ready))
endmodule

bind coupled_ar3_population_step cpop_checker u_cpop_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_valid(sample.valid),
	.s_ready(sample.ready),
	.s_op(sample.operation),
	.r_valid(result.valid),
	.r_ready(result.ready),
	.r_sum(result.population_sum)
);
